// ----- design/euler_pose_to_transform_top_defines.svh -----
// assertion macros for the euler pose to transform block
`ifndef EULER_POSE_TO_TRANSFORM_TOP_DEFINES_SVH
`define EULER_POSE_TO_TRANSFORM_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define EPT_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication check failed");

// condition that holds on every clock edge outside reset
`define EPT_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("invariant check failed");

`endif

// ----- design/ept_pkg.sv -----
// types, constants and helper functions for the euler pose to transform block
`default_nettype none

package ept_pkg;

   localparam int CORDIC_ITERS = 16;
   localparam int CW = 34;
   localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [CW-1:0] PI_Q30 = 34'sd3373259426;
   localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
   localparam logic signed [15:0] ANGLE_LIMIT = 16'sd25736;
   localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
   localparam int LATENCY = CORDIC_ITERS + 5;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] yaw_angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m02;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } pos_type;

   function automatic logic signed [CW-1:0] atan_q30(input int idx);
      logic signed [CW-1:0] r;
      case (idx)
         0: r = 34'sd843314856;
         1: r = 34'sd497837829;
         2: r = 34'sd263043836;
         3: r = 34'sd133525158;
         4: r = 34'sd67021686;
         5: r = 34'sd33543515;
         6: r = 34'sd16775850;
         7: r = 34'sd8388437;
         8: r = 34'sd4194282;
         9: r = 34'sd2097149;
         10: r = 34'sd1048575;
         11: r = 34'sd524287;
         12: r = 34'sd262143;
         13: r = 34'sd131071;
         14: r = 34'sd65535;
         15: r = 34'sd32767;
         default: r = '0;
      endcase
      return r;
   endfunction

   // round half up by sh bits, saturate to plus or minus one in q1.14
   function automatic logic signed [15:0] rnd_sat(input logic signed [47:0] v,
                                                  input int sh);
      logic signed [47:0] r;
      logic signed [15:0] q;
      r = (v + (48'sd1 <<< (sh - 1))) >>> sh;
      if (r > 48'sd16384) begin
         q = ONE_Q14;
      end else if (r < -48'sd16384) begin
         q = -ONE_Q14;
      end else begin
         q = r[15:0];
      end
      return q;
   endfunction

endpackage

`default_nettype wire

// ----- design/euler_pose_to_transform_top.sv -----
// euler pose to homogeneous transform, pipelined cordic and matrix product
`default_nettype none
`include "euler_pose_to_transform_top_defines.svh"

// Takes one pose per clock while busy is low (busy is high only in reset) and
// returns the rotation Rz*Ry*Rx in Q1.14 plus the unchanged translation,
// one strobe on rsp_valid per item. The pipeline is made up of the
// 16 unrolled cordic stages for the three angles, plus angle folding,
// sine/cosine rounding and three multiply/round stages. Results cannot be
// held off, so rsp_data must be taken in the cycle rsp_valid is high.
module euler_pose_to_transform_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ept_pkg::req_type  req_data,
   output logic              busy,
   output logic              rsp_valid,
   output ept_pkg::rsp_type  rsp_data
);
   import ept_pkg::*;

   localparam int NS = CORDIC_ITERS;

   logic accept;
   logic signed [15:0] ang [0:2];
   logic signed [15:0] ang_c [0:2];
   logic signed [CW-1:0] z0 [0:2];

   logic signed [CW-1:0] x_ff [0:NS][0:2];
   logic signed [CW-1:0] y_ff [0:NS][0:2];
   logic signed [CW-1:0] z_ff [0:NS][0:2];
   logic                 flip_ff [0:NS][0:2];
   logic signed [CW-1:0] x_in [0:NS][0:2];
   logic signed [CW-1:0] y_in [0:NS][0:2];
   logic signed [CW-1:0] z_in [0:NS][0:2];
   logic                 flip_in [0:NS][0:2];
   logic                 vld_ff [0:NS];
   pos_type              pos_ff [0:NS];

   // sine and cosine stage: index 0 roll, 1 pitch, 2 yaw
   logic signed [15:0] s_ff [0:2];
   logic signed [15:0] c_ff [0:2];
   logic signed [CW-1:0] xf [0:2];
   logic signed [CW-1:0] yf [0:2];
   logic               sc_vld_ff;
   pos_type            sc_pos_ff;

   // first product stage
   logic signed [29:0] czsy_ff, szsy_ff, czcy_ff, szcy_ff, cysx_ff, cycx_ff;
   logic signed [29:0] szcx_ff, szsx_ff, czcx_ff, czsx_ff;
   logic signed [15:0] sx1_ff, cx1_ff, sy1_ff;
   logic               p1_vld_ff;
   pos_type            p1_pos_ff;

   // second product stage
   logic signed [43:0] t01_ff, t02_ff, t11_ff, t12_ff;
   logic signed [29:0] b01_ff, b02_ff, b11_ff, b12_ff;
   logic signed [29:0] czcy2_ff, szcy2_ff, cysx2_ff, cycx2_ff;
   logic signed [15:0] sy2_ff;
   logic               p2_vld_ff;
   pos_type            p2_pos_ff;

   rsp_type            rsp_ff;
   logic               rsp_vld_ff;

   assign busy   = reset;
   assign accept = start & ~busy;

   // clamp and fold each angle into plus or minus half pi
   always_comb begin
      ang[0] = req_data.roll_angle;
      ang[1] = req_data.pitch_angle;
      ang[2] = req_data.yaw_angle;
      for (int l = 0; l < 3; l++) begin
         if (ang[l] > ANGLE_LIMIT) begin
            ang_c[l] = ANGLE_LIMIT;
         end else if (ang[l] < -ANGLE_LIMIT) begin
            ang_c[l] = -ANGLE_LIMIT;
         end else begin
            ang_c[l] = ang[l];
         end
         z0[l] = CW'(ang_c[l]) <<< 17;
         x_in[0][l] = GAIN_Q30;
         y_in[0][l] = '0;
         if (z0[l] > HALF_PI_Q30) begin
            z_in[0][l] = z0[l] - PI_Q30;
            flip_in[0][l] = 1'b1;
         end else if (z0[l] < -HALF_PI_Q30) begin
            z_in[0][l] = z0[l] + PI_Q30;
            flip_in[0][l] = 1'b1;
         end else begin
            z_in[0][l] = z0[l];
            flip_in[0][l] = 1'b0;
         end
      end
      // one micro-rotation per stage
      for (int i = 0; i < NS; i++) begin
         for (int l = 0; l < 3; l++) begin
            flip_in[i+1][l] = flip_ff[i][l];
            if (!z_ff[i][l][CW-1]) begin
               x_in[i+1][l] = x_ff[i][l] - (y_ff[i][l] >>> i);
               y_in[i+1][l] = y_ff[i][l] + (x_ff[i][l] >>> i);
               z_in[i+1][l] = z_ff[i][l] - atan_q30(i);
            end else begin
               x_in[i+1][l] = x_ff[i][l] + (y_ff[i][l] >>> i);
               y_in[i+1][l] = y_ff[i][l] - (x_ff[i][l] >>> i);
               z_in[i+1][l] = z_ff[i][l] + atan_q30(i);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= NS; i++) begin
         for (int l = 0; l < 3; l++) begin
            x_ff[i][l]    <= x_in[i][l];
            y_ff[i][l]    <= y_in[i][l];
            z_ff[i][l]    <= z_in[i][l];
            flip_ff[i][l] <= flip_in[i][l];
         end
      end
      pos_ff[0] <= '{x: req_data.pos_x, y: req_data.pos_y, z: req_data.pos_z};
      for (int i = 1; i <= NS; i++) begin
         pos_ff[i] <= pos_ff[i-1];
      end
      if (reset) begin
         for (int i = 0; i <= NS; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= accept;
         for (int i = 1; i <= NS; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         xf[l] = flip_ff[NS][l] ? -x_ff[NS][l] : x_ff[NS][l];
         yf[l] = flip_ff[NS][l] ? -y_ff[NS][l] : y_ff[NS][l];
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 3; l++) begin
         c_ff[l] <= rnd_sat(48'(xf[l]), 16);
         s_ff[l] <= rnd_sat(48'(yf[l]), 16);
      end
      sc_pos_ff <= pos_ff[NS];

      czsy_ff <= 30'(c_ff[2]) * 30'(s_ff[1]);
      szsy_ff <= 30'(s_ff[2]) * 30'(s_ff[1]);
      czcy_ff <= 30'(c_ff[2]) * 30'(c_ff[1]);
      szcy_ff <= 30'(s_ff[2]) * 30'(c_ff[1]);
      cysx_ff <= 30'(c_ff[1]) * 30'(s_ff[0]);
      cycx_ff <= 30'(c_ff[1]) * 30'(c_ff[0]);
      szcx_ff <= 30'(s_ff[2]) * 30'(c_ff[0]);
      szsx_ff <= 30'(s_ff[2]) * 30'(s_ff[0]);
      czcx_ff <= 30'(c_ff[2]) * 30'(c_ff[0]);
      czsx_ff <= 30'(c_ff[2]) * 30'(s_ff[0]);
      sx1_ff  <= s_ff[0];
      cx1_ff  <= c_ff[0];
      sy1_ff  <= s_ff[1];
      p1_pos_ff <= sc_pos_ff;

      t01_ff <= 44'(czsy_ff) * 44'(sx1_ff);
      t02_ff <= 44'(czsy_ff) * 44'(cx1_ff);
      t11_ff <= 44'(szsy_ff) * 44'(sx1_ff);
      t12_ff <= 44'(szsy_ff) * 44'(cx1_ff);
      b01_ff <= szcx_ff;
      b02_ff <= szsx_ff;
      b11_ff <= czcx_ff;
      b12_ff <= czsx_ff;
      czcy2_ff <= czcy_ff;
      szcy2_ff <= szcy_ff;
      cysx2_ff <= cysx_ff;
      cycx2_ff <= cycx_ff;
      sy2_ff   <= sy1_ff;
      p2_pos_ff <= p1_pos_ff;

      rsp_ff.m00 <= rnd_sat(48'(czcy2_ff), 14);
      rsp_ff.m01 <= rnd_sat(48'(t01_ff) - (48'(b01_ff) <<< 14), 28);
      rsp_ff.m02 <= rnd_sat(48'(t02_ff) + (48'(b02_ff) <<< 14), 28);
      rsp_ff.m10 <= rnd_sat(48'(szcy2_ff), 14);
      rsp_ff.m11 <= rnd_sat(48'(t11_ff) + (48'(b11_ff) <<< 14), 28);
      rsp_ff.m12 <= rnd_sat(48'(t12_ff) - (48'(b12_ff) <<< 14), 28);
      rsp_ff.m20 <= -sy2_ff;
      rsp_ff.m21 <= rnd_sat(48'(cysx2_ff), 14);
      rsp_ff.m22 <= rnd_sat(48'(cycx2_ff), 14);
      rsp_ff.out_x <= p2_pos_ff.x;
      rsp_ff.out_y <= p2_pos_ff.y;
      rsp_ff.out_z <= p2_pos_ff.z;

      if (reset) begin
         sc_vld_ff  <= 1'b0;
         p1_vld_ff  <= 1'b0;
         p2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         sc_vld_ff  <= vld_ff[NS];
         p1_vld_ff  <= sc_vld_ff;
         p2_vld_ff  <= p1_vld_ff;
         rsp_vld_ff <= p2_vld_ff;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   `EPT_ASSERT_IMPL(a_latency, rsp_valid, $past(start && !busy, LATENCY))
   `EPT_ASSERT_IMPL(a_pass_x, rsp_valid, rsp_data.out_x == $past(req_data.pos_x, LATENCY))
   `EPT_ASSERT_IMPL(a_m00_range, rsp_valid,
                    rsp_data.m00 <= ONE_Q14 && rsp_data.m00 >= -ONE_Q14)
   `EPT_ASSERT_ALWAYS(a_no_busy, !busy)

endmodule

`default_nettype wire

// ----- sim/euler_pose_to_transform_checker.sv -----
// checker that predicts the transform for each accepted pose and compares results
`timescale 1ns / 100ps

module euler_pose_to_transform_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  ept_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  ept_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);
   import ept_pkg::*;

   rsp_type transform_q[$];

   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_clip(longint v, int s);
      longint r;
      r = shr_floor(v + (64'sd1 <<< (s - 1)), s);
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r;
   endfunction

   function automatic void angle_sin_cos(input logic signed [15:0] a, output longint s,
                                         output longint c);
      longint ang, z, x, y, nx, ny;
      longint atans[16];
      bit flip;
      atans = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                131071, 65535, 32767};
      ang = a;
      flip = 0;
      x = 652032874;
      y = 0;
      if (ang > 25736) ang = 25736;
      if (ang < -25736) ang = -25736;
      z = ang * 131072;
      if (z > 1686629713) begin
         z = z - 64'sd3373259426;
         flip = 1;
      end else if (z < -1686629713) begin
         z = z + 64'sd3373259426;
         flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - shr_floor(y, i);
            ny = y + shr_floor(x, i);
            z = z - atans[i];
         end else begin
            nx = x + shr_floor(y, i);
            ny = y - shr_floor(x, i);
            z = z + atans[i];
         end
         x = nx;
         y = ny;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = round_clip(x, 16);
      s = round_clip(y, 16);
   endfunction

   function automatic rsp_type pose_transform(req_type p);
      rsp_type t;
      longint sx, cx, sy, cy, sz, cz;
      angle_sin_cos(p.roll_angle, sx, cx);
      angle_sin_cos(p.pitch_angle, sy, cy);
      angle_sin_cos(p.yaw_angle, sz, cz);
      t.m00 = 16'(round_clip(cz * cy, 14));
      t.m01 = 16'(round_clip(cz * sy * sx - sz * cx * 16384, 28));
      t.m02 = 16'(round_clip(cz * sy * cx + sz * sx * 16384, 28));
      t.m10 = 16'(round_clip(sz * cy, 14));
      t.m11 = 16'(round_clip(sz * sy * sx + cz * cx * 16384, 28));
      t.m12 = 16'(round_clip(sz * sy * cx - cz * sx * 16384, 28));
      t.m20 = 16'(-sy);
      t.m21 = 16'(round_clip(cy * sx, 14));
      t.m22 = 16'(round_clip(cy * cx, 14));
      t.out_x = p.pos_x;
      t.out_y = p.pos_y;
      t.out_z = p.pos_z;
      return t;
   endfunction

   task automatic compare_field(string name, longint want, longint got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (transform_q.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result expected none actual %h", $time, rsp_data);
         end else begin
            want = transform_q.pop_front();
            compare_field("m00", want.m00, rsp_data.m00);
            compare_field("m01", want.m01, rsp_data.m01);
            compare_field("m02", want.m02, rsp_data.m02);
            compare_field("m10", want.m10, rsp_data.m10);
            compare_field("m11", want.m11, rsp_data.m11);
            compare_field("m12", want.m12, rsp_data.m12);
            compare_field("m20", want.m20, rsp_data.m20);
            compare_field("m21", want.m21, rsp_data.m21);
            compare_field("m22", want.m22, rsp_data.m22);
            compare_field("out_x", want.out_x, rsp_data.out_x);
            compare_field("out_y", want.out_y, rsp_data.out_y);
            compare_field("out_z", want.out_z, rsp_data.out_z);
         end
      end
      if (!reset && start && !busy) transform_q.push_back(pose_transform(req_data));
      pending = transform_q.size();
   end
endmodule

// ----- sim/tb_euler_pose_to_transform_top.sv -----
// testbench top: pose stimulus, clock, reset and verdict
`timescale 1ns / 100ps

module tb_euler_pose_to_transform_top;
   import ept_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   req_type req_data = '0;
   logic busy, rsp_valid;
   rsp_type rsp_data;
   int fail_count, pending;
   int cycle_count = 0;
   logic signed [15:0] edge_angles[10] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868,
      -16'sd12868, 16'sd32767, -16'sd32768, 16'sd6434, -16'sd1, 16'sd1};

   euler_pose_to_transform_top dut (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   euler_pose_to_transform_checker chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic signed [15:0] pick_angle();
      case ($urandom_range(0, 9))
         0: return 16'($urandom);
         1: return edge_angles[$urandom_range(0, 9)];
         default: return 16'($signed(17'($urandom_range(0, 51472)) - 17'sd25736));
      endcase
   endfunction

   task automatic send_pose(req_type p, bit allow_gap);
      int gap;
      if (allow_gap && $urandom_range(0, 3) == 0) begin
         start <= 0;
         gap = $urandom_range(1, 5);
         repeat (gap) @(negedge clock);
      end
      start <= 1;
      req_data <= p;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      req_type p;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      for (int i = 0; i < 20; i++) begin
         p.pos_x = (i % 2) ? 32'h7fffffff : 32'h80000000;
         p.pos_y = (i % 2) ? 32'h80000000 : 32'hffffffff;
         p.pos_z = (i % 3 == 0) ? 32'h0 : 32'h55aa33cc;
         p.roll_angle = edge_angles[i % 10];
         p.pitch_angle = edge_angles[(i + 3) % 10];
         p.yaw_angle = edge_angles[(i * 7) % 10];
         send_pose(p, 0);
      end
      for (int i = 0; i < 1550; i++) begin
         p.pos_x = $urandom;
         p.pos_y = $urandom;
         p.pos_z = $urandom;
         p.roll_angle = pick_angle();
         p.pitch_angle = pick_angle();
         p.yaw_angle = pick_angle();
         if (i == 700) begin
            start <= 0;
            while (pending != 0) @(negedge clock);
         end
         send_pose(p, i < 1300);
      end
      start <= 0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
